### src/can_payload_segmenter_macros.svh
// ----------------------------------------------------------------------------
// can_payload_segmenter assertion macros
// Concurrent check macros shared by the RTL; empty under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef CAN_PAYLOAD_SEGMENTER_MACROS_SVH
`define CAN_PAYLOAD_SEGMENTER_MACROS_SVH

`ifndef SYNTHESIS
// Check that an expression holds at every clock outside reset.
`define CPS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Check that a consequent holds in the same cycle as its antecedent.
`define CPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Check that a consequent holds in the cycle after its antecedent.
`define CPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CPS_ASSERT_ALWAYS(lbl, expr, msg)
`define CPS_ASSERT_IMPL(lbl, ante, cons, msg)
`define CPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### src/cps_pkg.sv
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types, constants and the CRC-16/XMODEM byte step.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int CPS_MAX_PAYLOAD = 4096;
  localparam int QDEPTH          = 3;
  localparam int QCNT_W          = $clog2(QDEPTH + 1);

  localparam logic [15:0] SHORT_OFFSET_MAX = 16'd252;
  localparam logic [15:0] SHORT_MAX_BYTES  = 16'd6;
  localparam logic [2:0]  CHUNK_CAP_SHORT  = 3'd7;
  localparam logic [2:0]  CHUNK_CAP_LONG   = 3'd6;
  localparam logic [3:0]  FINAL_LEN        = 4'd6;
  localparam logic [15:0] CRC_POLY         = 16'h1021;

  localparam logic [7:0] RST_TYPE_SHORT     = 8'd8;
  localparam logic [7:0] RST_TYPE_FILL      = 8'd5;
  localparam logic [7:0] RST_TYPE_FILL_LONG = 8'd6;
  localparam logic [7:0] RST_TYPE_PROCESS   = 8'd7;

  typedef enum logic [7:0] {
    REG_MASTER_ID      = 8'd0,
    REG_PROCESS_CMD    = 8'd1,
    REG_TYPE_SHORT     = 8'd2,
    REG_TYPE_FILL      = 8'd3,
    REG_TYPE_FILL_LONG = 8'd4,
    REG_TYPE_PROCESS   = 8'd5
  } reg_index_t;

  typedef struct packed {
    logic [7:0]  target;
    logic [7:0]  ftype;
    logic [3:0]  len;
    logic [63:0] data;
    logic        last;
  } frame_t;

  typedef struct packed {
    logic [QCNT_W-1:0] level;
    logic              pop;
    logic [1:0]        push_n;
  } outq_status_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### src/can_payload_segmenter.sv
// A byte request's frame is registered into the output queue and is valid once at its head.
// Throughput: one byte request per cycle while two queue slots are free; a byte that
//   closes a payload while flushing a fill frame yields two frames, and the input then
//   stalls while the three-entry output queue drains, one frame per cycle if out_stall is low.
// Reset (rst, synchronous): clears payload state, empties the queue, loads the
//   register defaults (type codes 8/5/6/7, ids zero).
// ----------------------------------------------------------------------------
// can_payload_segmenter
// Splits a byte-serial command payload into CAN short, fill and final frames.
// ----------------------------------------------------------------------------
`include "can_payload_segmenter_macros.svh"

module can_payload_segmenter #(
  parameter int MAX_PAYLOAD = cps_pkg::CPS_MAX_PAYLOAD
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // byte requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  target_id,
  input  logic [7:0]  payload_byte,
  input  logic        last_byte,
  // frame requests
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  frame_target,
  output logic [7:0]  frame_type,
  output logic [3:0]  frame_len,
  output logic [63:0] frame_data,
  output logic        last_frame
);
  import cps_pkg::*;

  logic         accept;
  logic [1:0]   push_n;
  frame_t       res0, res1, head;
  logic         q_full;
  outq_status_t q_status;

  // take a byte whenever the queue has room for the two frames it may cause
  assign accept   = in_valid && !in_stall;
  assign in_stall = q_full;

  cps_framer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_framer (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .target_id    (target_id),
    .payload_byte (payload_byte),
    .last_byte    (last_byte),
    .push_n       (push_n),
    .res0         (res0),
    .res1         (res1)
  );

  // output queue parts the input handshake from the output stall
  cps_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .res0      (res0),
    .res1      (res1),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .full      (q_full),
    .status    (q_status)
  );

  assign frame_target = head.target;
  assign frame_type   = head.ftype;
  assign frame_len    = head.len;
  assign frame_data   = head.data;
  assign last_frame   = head.last;

  // queue level tracks pushes and pops exactly
  `CPS_ASSERT_NEXT(a_level_track, 1'b1, q_status.level == $past(q_status.level) - QCNT_W'($past(q_status.pop)) + QCNT_W'($past(q_status.push_n)), "queue level mismatch")
  // a byte that yields two frames must find two free slots
  `CPS_ASSERT_IMPL(a_two_room, push_n == 2'd2, q_status.level <= QCNT_W'(QDEPTH - 2) || (q_status.level == QCNT_W'(QDEPTH - 1) && q_status.pop), "queue overflow")
  // every delivered frame carries one to eight bytes
  `CPS_ASSERT_IMPL(a_len_range, out_valid, frame_len != 4'd0 && frame_len <= 4'd8, "frame length out of range")
  // no push without an accepted byte
  `CPS_ASSERT_IMPL(a_push_accept, push_n != 2'd0, accept, "frame pushed without a byte")

endmodule

### src/cps_framer.sv
// ----------------------------------------------------------------------------
// cps_framer
// Configuration registers, payload state and per-byte frame building.
// ----------------------------------------------------------------------------
module cps_framer #(
  parameter int MAX_PAYLOAD = cps_pkg::CPS_MAX_PAYLOAD
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [7:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              accept,
  input  logic [7:0]        target_id,
  input  logic [7:0]        payload_byte,
  input  logic              last_byte,
  output logic [1:0]        push_n,
  output cps_pkg::frame_t   res0,
  output cps_pkg::frame_t   res1
);
  import cps_pkg::*;

  localparam logic [15:0] MaxCount = 16'(MAX_PAYLOAD);

  logic [7:0]  master_id, process_command;
  logic [7:0]  type_short, type_fill, type_fill_long, type_process;

  logic [15:0] byte_count, running_crc;
  logic [55:0] frame_bytes;
  logic [2:0]  frame_fill;
  logic [7:0]  latched_target;

  logic [7:0]  tgt;
  logic        take, cap_short, full, chunk_emit;
  logic [15:0] start0, cnt1, crc1;
  logic [2:0]  fill1;
  logic [55:0] fb1;
  frame_t      chunk_f, end_f;

  // config writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      master_id       <= '0;
      process_command <= '0;
      type_short      <= RST_TYPE_SHORT;
      type_fill       <= RST_TYPE_FILL;
      type_fill_long  <= RST_TYPE_FILL_LONG;
      type_process    <= RST_TYPE_PROCESS;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MASTER_ID:      master_id       <= cfg_data;
        REG_PROCESS_CMD:    process_command <= cfg_data;
        REG_TYPE_SHORT:     type_short      <= cfg_data;
        REG_TYPE_FILL:      type_fill       <= cfg_data;
        REG_TYPE_FILL_LONG: type_fill_long  <= cfg_data;
        REG_TYPE_PROCESS:   type_process    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    tgt       = (byte_count == 16'd0) ? target_id : latched_target;
    take      = byte_count < MaxCount;
    start0    = byte_count - {13'd0, frame_fill};
    cap_short = start0 <= SHORT_OFFSET_MAX;
    crc1      = take ? crc_byte(running_crc, payload_byte) : running_crc;
    cnt1      = take ? byte_count + 16'd1 : byte_count;
    fill1     = take ? frame_fill + 3'd1 : frame_fill;
    fb1       = frame_bytes;
    for (int i = 0; i < 7; i++) begin
      if (take && frame_fill == 3'(i)) begin
        fb1[55-8*i -: 8] = payload_byte;
      end
    end
    full       = take && (fill1 >= (cap_short ? CHUNK_CAP_SHORT : CHUNK_CAP_LONG));
    chunk_emit = full || (last_byte && cnt1 > SHORT_MAX_BYTES && fill1 != 3'd0);

    // fill frame; its start offset is always the pending chunk's start
    chunk_f.target = tgt;
    chunk_f.last   = 1'b0;
    if (cap_short) begin
      chunk_f.ftype = type_fill;
      chunk_f.len   = {1'b0, fill1} + 4'd1;
      chunk_f.data  = {start0[7:0], fb1};
    end else begin
      chunk_f.ftype = type_fill_long;
      chunk_f.len   = {1'b0, fill1} + 4'd2;
      chunk_f.data  = {start0[15:8], start0[7:0], fb1[55:8]};
    end

    // closing frame: short single frame or final length/CRC frame
    end_f.target = tgt;
    end_f.last   = 1'b1;
    if (cnt1 <= SHORT_MAX_BYTES) begin
      end_f.ftype = type_short;
      end_f.len   = cnt1[3:0] + 4'd2;
      end_f.data  = {master_id, process_command, fb1[55:8]};
    end else begin
      end_f.ftype = type_process;
      end_f.len   = FINAL_LEN;
      end_f.data  = {master_id, process_command, cnt1, crc1, 16'h0000};
    end

    res0   = chunk_emit ? chunk_f : end_f;
    res1   = end_f;
    push_n = accept ? ({1'b0, chunk_emit} + {1'b0, last_byte}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      running_crc    <= '0;
      frame_bytes    <= '0;
      frame_fill     <= '0;
      latched_target <= '0;
    end else if (accept) begin
      latched_target <= tgt;
      if (last_byte) begin
        byte_count  <= '0;
        running_crc <= '0;
        frame_bytes <= '0;
        frame_fill  <= '0;
      end else begin
        byte_count  <= cnt1;
        running_crc <= crc1;
        frame_bytes <= full ? 56'd0 : fb1;
        frame_fill  <= full ? 3'd0 : fill1;
      end
    end
  end

endmodule

### src/cps_outq.sv
// ----------------------------------------------------------------------------
// cps_outq
// Small shifting frame queue; head entry drives the output channel.
// ----------------------------------------------------------------------------
module cps_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            push_n,
  input  cps_pkg::frame_t       res0,
  input  cps_pkg::frame_t       res1,
  input  logic                  out_stall,
  output logic                  out_valid,
  output cps_pkg::frame_t       head,
  output logic                  full,
  output cps_pkg::outq_status_t status
);
  import cps_pkg::*;

  frame_t            q      [QDEPTH];
  frame_t            q_next [QDEPTH];
  logic [QCNT_W-1:0] level, level_next, base;
  logic              pop;

  always_comb begin
    pop  = (level != '0) && !out_stall;
    base = level - QCNT_W'(pop);
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) begin
        q_next[i] = q[i+1];
      end else begin
        q_next[i] = q[i];
      end
      if (push_n != 2'd0 && base == QCNT_W'(i)) begin
        q_next[i] = res0;
      end
      if (push_n == 2'd2 && base + QCNT_W'(1) == QCNT_W'(i)) begin
        q_next[i] = res1;
      end
    end
    level_next = base + QCNT_W'(push_n);
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else begin
      level <= level_next;
    end
  end

  assign out_valid     = level != '0;
  assign head          = q[0];
  // hold off requests until two slots are free
  assign full          = level >= QCNT_W'(QDEPTH - 1);
  assign status.level  = level;
  assign status.pop    = pop;
  assign status.push_n = push_n;

endmodule
